// ===== hw/rtl/iir_direct_form_two_macros.svh =====
// assertion helpers for the iir filter checker
`ifndef IIR_DIRECT_FORM_TWO_MACROS_SVH
`define IIR_DIRECT_FORM_TWO_MACROS_SVH

// same-cycle implication
`define IIRDF2_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iir_direct_form_two check failed");

// next-cycle implication
`define IIRDF2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iir_direct_form_two check failed");

`endif

// ===== hw/rtl/iirdf2_pkg.sv =====
package iirdf2_pkg;

    localparam int DefaultOrder = 2;
    localparam int MaxOrder     = 3;

    localparam int SampleW    = 16;
    localparam int CoefW      = 18;
    localparam int NodeW      = 24;
    localparam int CfgIndexW  = 4;
    localparam int CoefIdxW   = 2;
    localparam int RoundShift = 14;

    localparam logic [CfgIndexW-1:0] CfgInputGain  = 4'd0;
    localparam logic [CfgIndexW-1:0] CfgDirectGain = 4'd1;
    localparam logic [CfgIndexW-1:0] CfgFirstCoef  = 4'd2;
    localparam logic [CfgIndexW-1:0] CfgNumRegs    = 4'd8;

    localparam logic signed [CoefW-1:0] GainReset = 18'sd16384;

endpackage

// ===== hw/rtl/iir_direct_form_two.sv =====
// samples are taken one at a time: a new one is accepted only once the sequencer is back
// in idle, since the 2*ORDER+2 products are all formed by the single shared
// multiply-accumulate, one per cycle
// a result still held by out_stall holds the final step until it is taken
// reset: async active low; gains to 1.0, other coefficients to zero,
// node history cleared, no result pending
module iir_direct_form_two
    import iirdf2_pkg::*;
#(
    parameter int ORDER = DefaultOrder
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SampleW-1:0]   sample_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SampleW-1:0]   sample_out,
    output logic                        saturated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CfgIndexW-1:0]        cfg_index,
    input  logic signed [CoefW-1:0]     cfg_data
);

    localparam int SlotW = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int CntW  = $clog2(ORDER + 1);
    localparam int ProdW = CoefW + NodeW;
    localparam int AccW  = ProdW + 4;
    localparam int RndW  = AccW - RoundShift;

    localparam logic signed [AccW-1:0] RoundAdd = AccW'(1) << (RoundShift - 1);
    localparam logic signed [RndW-1:0] NodeHi =
        {{(RndW - NodeW + 1){1'b0}}, {(NodeW - 1){1'b1}}};
    localparam logic signed [RndW-1:0] NodeLo =
        {{(RndW - NodeW + 1){1'b1}}, {(NodeW - 1){1'b0}}};
    localparam logic signed [RndW-1:0] OutHi =
        {{(RndW - SampleW + 1){1'b0}}, {(SampleW - 1){1'b1}}};
    localparam logic signed [RndW-1:0] OutLo =
        {{(RndW - SampleW + 1){1'b1}}, {(SampleW - 1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB,
        ST_NODE,
        ST_FF,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [CntW-1:0]            cnt_reg, cnt_next;
    logic [SlotW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [SlotW-1:0]           newest_reg, newest_next;
    logic [SlotW-1:0]           wr_slot;
    logic                       hist_wr;
    logic signed [SampleW-1:0]  sample_reg, sample_next;
    logic signed [NodeW-1:0]    node_reg, node_next;
    logic signed [AccW-1:0]     acc_reg, acc_next;
    logic                       sat_reg, sat_next;
    logic signed [ProdW-1:0]    prod_reg;
    logic                       prod_vld_reg;
    logic                       prod_neg_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SampleW-1:0]  sample_out_reg, sample_out_next;
    logic                       saturated_reg, saturated_next;

    logic signed [NodeW-1:0]    hist_reg [ORDER];
    logic signed [CoefW-1:0]    input_gain_reg;
    logic signed [CoefW-1:0]    direct_gain_reg;
    logic signed [CoefW-1:0]    fb_coef_reg [MaxOrder];
    logic signed [CoefW-1:0]    ff_coef_reg [MaxOrder];

    logic [CoefIdxW-1:0]        coef_idx;
    logic signed [NodeW-1:0]    hist_rd;
    logic signed [CoefW-1:0]    mul_a;
    logic signed [NodeW-1:0]    mul_b;
    logic                       mul_neg;
    logic                       mul_issue;
    logic signed [ProdW-1:0]    mul_res;
    logic signed [AccW-1:0]     prod_ext;
    logic signed [AccW-1:0]     term;
    logic signed [AccW-1:0]     acc_sum;
    logic signed [AccW-1:0]     acc_rnd;
    logic signed [RndW-1:0]     rnd_val;
    logic signed [NodeW-1:0]    node_clip;
    logic                       node_sat;
    logic signed [SampleW-1:0]  out_clip;
    logic                       out_sat;
    logic [CfgIndexW-1:0]       cfg_off;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;
    assign cfg_ready  = 1'b1;

    // shared multiplier operand select
    assign coef_idx = CoefIdxW'(cnt_reg - 1'b1);
    assign hist_rd  = hist_reg[rd_ptr_reg];

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        mul_issue = 1'b0;
        unique case (state_reg)
            ST_FB:
            begin
                mul_issue = 1'b1;
                if (cnt_reg == '0)
                begin
                    mul_a = input_gain_reg;
                    mul_b = NodeW'(sample_reg);
                end
                else
                begin
                    mul_a   = fb_coef_reg[coef_idx];
                    mul_b   = hist_rd;
                    mul_neg = 1'b1;
                end
            end
            ST_FF:
            begin
                mul_issue = 1'b1;
                if (cnt_reg == '0)
                begin
                    mul_a = direct_gain_reg;
                    mul_b = node_reg;
                end
                else
                begin
                    mul_a = ff_coef_reg[coef_idx];
                    mul_b = hist_rd;
                end
            end
            default:
            begin
                mul_issue = 1'b0;
            end
        endcase
    end

    assign mul_res  = mul_a * mul_b;
    assign prod_ext = AccW'(prod_reg);
    assign term     = prod_vld_reg ? (prod_neg_reg ? -prod_ext : prod_ext) : '0;
    assign acc_sum  = acc_reg + term;
    assign acc_rnd  = acc_sum + RoundAdd;
    assign rnd_val  = $signed(acc_rnd[AccW-1:RoundShift]);

    // rounding and saturation
    always_comb
    begin
        node_sat = 1'b0;
        out_sat  = 1'b0;
        if (rnd_val > NodeHi)
        begin
            node_clip = {1'b0, {(NodeW - 1){1'b1}}};
            node_sat  = 1'b1;
        end
        else if (rnd_val < NodeLo)
        begin
            node_clip = {1'b1, {(NodeW - 1){1'b0}}};
            node_sat  = 1'b1;
        end
        else
        begin
            node_clip = rnd_val[NodeW-1:0];
        end
        if (rnd_val > OutHi)
        begin
            out_clip = {1'b0, {(SampleW - 1){1'b1}}};
            out_sat  = 1'b1;
        end
        else if (rnd_val < OutLo)
        begin
            out_clip = {1'b1, {(SampleW - 1){1'b0}}};
            out_sat  = 1'b1;
        end
        else
        begin
            out_clip = rnd_val[SampleW-1:0];
        end
    end

    assign wr_slot = (newest_reg == SlotW'(ORDER - 1)) ? '0 : newest_reg + 1'b1;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        newest_next     = newest_reg;
        sample_next     = sample_reg;
        node_next       = node_reg;
        acc_next        = acc_reg;
        sat_next        = sat_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        saturated_next  = saturated_reg;
        hist_wr         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample_in;
                    cnt_next    = '0;
                    acc_next    = '0;
                    rd_ptr_next = newest_reg;
                    sat_next    = 1'b0;
                    state_next  = ST_FB;
                end
            end
            ST_FB, ST_FF:
            begin
                acc_next = acc_sum;
                if (cnt_reg != '0)
                begin
                    rd_ptr_next = (rd_ptr_reg == '0) ? SlotW'(ORDER - 1)
                                                     : rd_ptr_reg - 1'b1;
                end
                if (cnt_reg == CntW'(ORDER))
                begin
                    state_next = (state_reg == ST_FB) ? ST_NODE : ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_NODE:
            begin
                node_next   = node_clip;
                sat_next    = node_sat;
                acc_next    = '0;
                cnt_next    = '0;
                rd_ptr_next = newest_reg;
                state_next  = ST_FF;
            end
            ST_DONE:
            begin
                // fold in the last product so a held result keeps its sum
                acc_next = acc_sum;
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = out_clip;
                    saturated_next  = sat_reg | out_sat;
                    hist_wr         = 1'b1;
                    newest_next     = wr_slot;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_ptr_reg     <= '0;
            newest_reg     <= '0;
            prod_vld_reg   <= 1'b0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_ptr_reg     <= rd_ptr_next;
            newest_reg     <= newest_next;
            prod_vld_reg   <= mul_issue;
            sat_reg        <= sat_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        node_reg       <= node_next;
        acc_reg        <= acc_next;
        prod_reg       <= mul_res;
        prod_neg_reg   <= mul_neg;
        sample_out_reg <= sample_out_next;
        saturated_reg  <= saturated_next;
    end

    // node history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (hist_wr)
        begin
            hist_reg[wr_slot] <= node_reg;
        end
    end

    // coefficient registers
    assign cfg_off = cfg_index - CfgFirstCoef;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_gain_reg  <= GainReset;
            direct_gain_reg <= GainReset;
            for (int i = 0; i < MaxOrder; i++)
            begin
                fb_coef_reg[i] <= '0;
                ff_coef_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < CfgNumRegs))
        begin
            priority if (cfg_index == CfgInputGain)
            begin
                input_gain_reg <= cfg_data;
            end
            else if (cfg_index == CfgDirectGain)
            begin
                direct_gain_reg <= cfg_data;
            end
            else
            begin
                if (!cfg_off[0])
                begin
                    fb_coef_reg[cfg_off[CoefIdxW:1]] <= cfg_data;
                end
                else
                begin
                    ff_coef_reg[cfg_off[CoefIdxW:1]] <= cfg_data;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/iirdf2_checker.sv =====
`include "iir_direct_form_two_macros.svh"

module iirdf2_checker
    import iirdf2_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [SampleW-1:0] sample_out,
    input logic                      saturated
);

    // a sample transaction starts the sequencer
    `IIRDF2_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a result only appears at the end of a busy period
    `IIRDF2_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall))

    // a waiting result holds
    `IIRDF2_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out) && $stable(saturated))

endmodule

bind iir_direct_form_two iirdf2_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .saturated  (saturated)
);

// ===== test/iir_direct_form_two_tb.sv =====
module iir_direct_form_two_tb
    import iirdf2_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FilterOrder   = DefaultOrder;
    localparam int RandomPhases  = 10;
    localparam int ItemsPerPhase = 100;
    localparam int SettleCycles  = 2 * FilterOrder + 8;

    localparam logic [CfgIndexW-1:0] RegFeedbackOne   = CfgFirstCoef;
    localparam logic [CfgIndexW-1:0] RegForwardOne    = CfgFirstCoef + 4'd1;
    localparam logic [CfgIndexW-1:0] RegFeedbackTwo   = CfgFirstCoef + 4'd2;
    localparam logic [CfgIndexW-1:0] RegForwardTwo    = CfgFirstCoef + 4'd3;
    localparam logic [CfgIndexW-1:0] RegFeedbackThree = CfgFirstCoef + 4'd4;
    localparam logic [CfgIndexW-1:0] RegForwardThree  = CfgFirstCoef + 4'd5;
    localparam logic [CfgIndexW-1:0] RegIndexTop      = {CfgIndexW{1'b1}};

    localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
    localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;
    localparam logic signed [CoefW-1:0]   CoefMax   = 18'sh1ffff;
    localparam logic signed [CoefW-1:0]   CoefMin   = 18'sh20000;

    localparam longint NodeMax = (longint'(1) <<< (NodeW - 1)) - 1;
    localparam longint NodeMin = -(longint'(1) <<< (NodeW - 1));
    localparam longint OutMax  = (longint'(1) <<< (SampleW - 1)) - 1;
    localparam longint OutMin  = -(longint'(1) <<< (SampleW - 1));

    typedef struct packed {
        logic signed [SampleW-1:0] value;
        logic                      sat;
    } filter_result_t;

    class df2_scoreboard;
        int             ord;
        int             gain_in;
        int             gain_direct;
        int             fb_coef[MaxOrder];
        int             ff_coef[MaxOrder];
        int             node_mem[MaxOrder];
        int             newest;
        filter_result_t expected_q[$];
        int             failures;
        int             checked;
        int             clipped;
        int             samples;

        function new(int order);
            ord = order;
            gain_in = GainReset;
            gain_direct = GainReset;
            for (int d = 0; d < MaxOrder; d++)
            begin
                fb_coef[d] = 0;
                ff_coef[d] = 0;
                node_mem[d] = 0;
            end
            newest = 0;
            failures = 0;
            checked = 0;
            clipped = 0;
            samples = 0;
        endfunction

        function void write_coef(logic [CfgIndexW-1:0] idx, logic signed [CoefW-1:0] data);
            int d;
            d = (int'(idx) - int'(CfgFirstCoef)) >> 1;
            if (idx == CfgInputGain)
                gain_in = data;
            else if (idx == CfgDirectGain)
                gain_direct = data;
            else if (idx < CfgNumRegs)
            begin
                if (((idx - CfgFirstCoef) & 1) == 0)
                    fb_coef[d] = data;
                else
                    ff_coef[d] = data;
            end
        endfunction

        function void note_sample(logic signed [SampleW-1:0] smp);
            longint         fb_acc;
            longint         ff_acc;
            longint         node;
            longint         y;
            int             cur;
            int             slot;
            int             d;
            bit             clipped_now;
            filter_result_t r;
            fb_acc = longint'(gain_in) * longint'(smp);
            ff_acc = 0;
            clipped_now = 1'b0;
            cur = newest % ord;
            for (d = 0; d < ord; d++)
            begin
                slot = (cur + ord - d) % ord;
                fb_acc -= longint'(fb_coef[d]) * longint'(node_mem[slot]);
                ff_acc += longint'(ff_coef[d]) * longint'(node_mem[slot]);
            end
            node = (fb_acc + 64'sd8192) >>> RoundShift;
            if (node > NodeMax)
            begin
                node = NodeMax;
                clipped_now = 1'b1;
            end
            else if (node < NodeMin)
            begin
                node = NodeMin;
                clipped_now = 1'b1;
            end
            cur = (cur + 1) % ord;
            node_mem[cur] = int'(node);
            newest = cur;
            ff_acc += longint'(gain_direct) * node;
            y = (ff_acc + 64'sd8192) >>> RoundShift;
            if (y > OutMax)
            begin
                y = OutMax;
                clipped_now = 1'b1;
            end
            else if (y < OutMin)
            begin
                y = OutMin;
                clipped_now = 1'b1;
            end
            r.value = y[SampleW-1:0];
            r.sat = clipped_now;
            expected_q.push_back(r);
            samples++;
        endfunction

        function void flag_error(string msg);
            failures++;
            if (failures <= 10)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void check_result(logic signed [SampleW-1:0] value, logic sat);
            filter_result_t want;
            if (expected_q.size() == 0)
            begin
                flag_error($sformatf("result %0d sat %0b with no sample outstanding",
                                     value, sat));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (sat === 1'b1)
                clipped++;
            if (value !== want.value)
                flag_error($sformatf("result %0d sample_out: expected %0d, got %0d",
                                     checked, want.value, value));
            if (sat !== want.sat)
                flag_error($sformatf("result %0d saturated: expected %0b, got %0b",
                                     checked, want.sat, sat));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [SampleW-1:0] sample_in;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [SampleW-1:0] sample_out;
    logic                      saturated;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CfgIndexW-1:0]      cfg_index;
    logic signed [CoefW-1:0]   cfg_data;

    df2_scoreboard sb;
    bit            steady;
    int            settings_cnt;

    iir_direct_form_two #(
        .ORDER(FilterOrder)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample_out(sample_out),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // leaves cfg_valid high so back-to-back writes need no extra step
    task automatic write_reg(input logic [CfgIndexW-1:0] idx,
                             input logic signed [CoefW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_coef(idx, data);
        @(negedge clk);
    endtask

    function automatic logic signed [CoefW-1:0] pick_coef(input bit tame);
        int kind;
        kind = tame ? 9 : $urandom_range(0, 9);
        case (kind)
            0:       pick_coef = CoefMin;
            1:       pick_coef = CoefMax;
            2, 3, 4: pick_coef = CoefW'($urandom);
            default: pick_coef = CoefW'($urandom_range(0, 12000)) - 18'sd6000;
        endcase
    endfunction

    function automatic logic signed [SampleW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       pick_sample = SampleMin;
            1:       pick_sample = SampleMax;
            2, 3, 4: pick_sample = SampleW'($urandom_range(0, 1023)) - 16'sd512;
            default: pick_sample = SampleW'($urandom);
        endcase
    endfunction

    task automatic program_random(input bit tame);
        for (int r = 0; r < CfgNumRegs; r++)
            write_reg(CfgIndexW'(r), pick_coef(tame));
        if ($urandom_range(0, 2) == 0)
            write_reg(CfgIndexW'($urandom_range(CfgNumRegs, RegIndexTop)), CoefW'($urandom));
        cfg_valid <= 1'b0;
        settings_cnt++;
    endtask

    task automatic send_samples(input logic signed [SampleW-1:0] items[$]);
        int gap;
        foreach (items[i])
        begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid  <= 1'b1;
            sample_in <= items[i];
            do
                @(posedge clk);
            while (in_stall);
            sb.note_sample(items[i]);
            @(negedge clk);
        end
        in_valid <= 1'b0;
    endtask

    task automatic collect_results();
        int hold;
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 3);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(sample_out, saturated);
            @(negedge clk);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SettleCycles) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic signed [SampleW-1:0] batch[$];
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample_in = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 1'b0;
        settings_cnt = 1;
        sb = new(FilterOrder);
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        fork
            collect_results();
        join_none
        @(negedge clk);

        // reset gains pass samples straight through
        batch = '{SampleMax, SampleMin, 16'sd0, 16'sd1, -16'sd1, 16'sd16384};
        send_samples(batch);
        drain();

        // out of range writes must not disturb anything, then extreme coefficients
        write_reg(CfgNumRegs, CoefMin);
        write_reg(RegIndexTop, CoefMax);
        write_reg(CfgInputGain, CoefMax);
        write_reg(CfgDirectGain, CoefMin);
        write_reg(RegFeedbackOne, CoefMin);
        write_reg(RegForwardOne, CoefMax);
        write_reg(RegFeedbackTwo, CoefMax);
        write_reg(RegForwardTwo, CoefMin);
        write_reg(RegFeedbackThree, CoefMax);
        write_reg(RegForwardThree, CoefMin);
        cfg_valid <= 1'b0;
        settings_cnt++;
        batch = '{SampleMax, SampleMax, SampleMax, SampleMax, SampleMin,
                  SampleMin, SampleMin, SampleMin, 16'sd0, 16'sd0};
        send_samples(batch);
        drain();

        // stable low-pass style setting
        write_reg(CfgInputGain, 18'sd16384);
        write_reg(CfgDirectGain, 18'sd8192);
        write_reg(RegFeedbackOne, -18'sd8192);
        write_reg(RegForwardOne, 18'sd8192);
        write_reg(RegFeedbackTwo, 18'sd4096);
        write_reg(RegForwardTwo, -18'sd4096);
        write_reg(RegFeedbackThree, 18'sd0);
        write_reg(RegForwardThree, 18'sd0);
        cfg_valid <= 1'b0;
        settings_cnt++;
        batch = '{SampleMax, SampleMin, 16'sd12345, -16'sd1, 16'sd0, 16'sd1,
                  SampleMin, SampleMax};
        send_samples(batch);
        drain();

        for (int n = 0; n < RandomPhases; n++)
        begin
            program_random(n % 2 == 0);
            steady = (n % 4 == 3);
            batch.delete();
            repeat (ItemsPerPhase) batch.push_back(pick_sample());
            send_samples(batch);
            drain();
        end
        steady = 1'b0;

        if (sb.pending() != 0)
            sb.flag_error($sformatf("%0d results never arrived", sb.pending()));
        $display("%0d samples filtered under %0d coefficient settings, %0d results compared",
                 sb.samples, settings_cnt, sb.checked);
        $display("%0d results saturated, %0d mismatches", sb.clipped, sb.failures);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
